// ===== src/apl_pkg.sv =====
package apl_pkg;

  localparam int OP_W     = 3;
  localparam int NODE_W   = 6;
  localparam int LINK_W   = 7;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // link code one past the last node index marks the end of a list
  localparam logic [LINK_W-1:0] LINK_NIL = 7'd64;

  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
  localparam logic [OP_W-1:0] OP_TRAVERSE  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd2;

  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_CLEAR,
    CMD_INS_HEAD,
    CMD_INS_AFTER,
    CMD_DELETE,
    CMD_TRAVERSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [STATUS_W-1:0]        status;
    logic [NODE_W-1:0]          pos;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         count;
    logic [NODE_W-1:0]          node;
  } cmd_t;

  typedef struct packed {
    logic                       link_we;
    logic                       val_we;
    logic [NODE_W-1:0]          waddr;
    logic [LINK_W-1:0]          link_wdata;
    logic signed [VALUE_W-1:0]  val_wdata;
    logic [NODE_W-1:0]          raddr;
  } mem_req_t;

endpackage

// ===== src/apl_if.sv =====
interface apl_in_if import apl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [NODE_W-1:0]         position;
  logic signed [VALUE_W-1:0] value;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, op, position, value, count, input ready);
  modport sink   (input valid, op, position, value, count, output ready);
endinterface

interface apl_out_if import apl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      has_value;
  logic signed [VALUE_W-1:0] element;
  logic [NODE_W-1:0]         node_index;
  logic                      last;

  modport source (output valid, status, has_value, element, node_index, last, input ready);
  modport sink   (input valid, status, has_value, element, node_index, last, output ready);
endinterface

// ===== src/apl_ram.sv =====
module apl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/apl_front.sv =====
module apl_front import apl_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  apl_in_if.sink     in_chan,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  // allocation is fully determined by the op stream, so it is tracked here
  logic [LINK_W-1:0] alloc_r, alloc_nxt;
  logic              full, bad_pos;

  assign full       = alloc_r >= LINK_W'(POOL_DEPTH);
  assign bad_pos    = {1'b0, in_chan.position} >= alloc_r;
  assign push_valid = in_chan.valid;
  assign in_chan.ready = push_ready;

  always_comb begin
    push_cmd.kind   = CMD_REPORT;
    push_cmd.status = STATUS_OK;
    push_cmd.pos    = in_chan.position;
    push_cmd.value  = in_chan.value;
    push_cmd.count  = in_chan.count;
    push_cmd.node   = alloc_r[NODE_W-1:0];
    alloc_nxt       = alloc_r;
    unique case (in_chan.op)
      OP_CLEAR: begin
        push_cmd.kind = CMD_CLEAR;
        alloc_nxt     = '0;
      end
      OP_INS_HEAD: begin
        if (full) begin
          push_cmd.status = STATUS_FULL;
        end else begin
          push_cmd.kind = CMD_INS_HEAD;
          alloc_nxt     = alloc_r + LINK_W'(1);
        end
      end
      OP_INS_AFTER: begin
        priority if (bad_pos) begin
          push_cmd.status = STATUS_BAD_POS;
        end else if (full) begin
          push_cmd.status = STATUS_FULL;
        end else begin
          push_cmd.kind = CMD_INS_AFTER;
          alloc_nxt     = alloc_r + LINK_W'(1);
        end
      end
      OP_DELETE: begin
        if (bad_pos) begin
          push_cmd.status = STATUS_BAD_POS;
        end else begin
          push_cmd.kind = CMD_DELETE;
        end
      end
      OP_TRAVERSE: begin
        push_cmd.kind = CMD_TRAVERSE;
      end
      default: begin
        push_cmd.kind = CMD_REPORT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
    end else if (in_chan.valid && push_ready) begin
      alloc_r <= alloc_nxt;
    end
  end

endmodule

// ===== src/apl_queue.sv =====
module apl_queue import apl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/apl_back.sv =====
module apl_back import apl_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  input  cmd_t                      pop_cmd,
  output logic                      pop_ready,
  apl_out_if.source                 out_chan,
  output mem_req_t                  mem_req,
  input  logic [LINK_W-1:0]         link_rdata,
  input  logic signed [VALUE_W-1:0] val_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_LD,
    ST_DEL_CHK,
    ST_DEL_RD,
    ST_TRV_RD,
    ST_TRV_EM
  } state_t;

  state_t                    state_r, state_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic [LINK_W-1:0]         head_r, head_nxt;
  logic [LINK_W-1:0]         nx_r, nx_nxt;
  logic [COUNT_W-1:0]        rem_r, rem_nxt;
  logic [NODE_W-1:0]         cur_r, cur_nxt;
  logic [NODE_W-1:0]         k_r, k_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic                      out_has_r, out_has_nxt;
  logic signed [VALUE_W-1:0] out_elem_r, out_elem_nxt;
  logic [NODE_W-1:0]         out_idx_r, out_idx_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free;
  logic                      em, em_has, em_last;
  logic [STATUS_W-1:0]       em_status;
  logic signed [VALUE_W-1:0] em_elem;
  logic [NODE_W-1:0]         em_idx;
  logic                      trv_fin;

  assign out_free = !out_valid_r || out_chan.ready;
  assign trv_fin  = (nx_r >= LINK_NIL) || (k_r == NODE_W'(POOL_DEPTH - 1));

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.has_value  = out_has_r;
  assign out_chan.element    = out_elem_r;
  assign out_chan.node_index = out_idx_r;
  assign out_chan.last       = out_last_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    head_nxt  = head_r;
    nx_nxt    = nx_r;
    rem_nxt   = rem_r;
    cur_nxt   = cur_r;
    k_nxt     = k_r;
    val_nxt   = val_r;
    pop_ready = 1'b0;
    mem_req   = '0;
    em        = 1'b0;
    em_status = STATUS_OK;
    em_has    = 1'b0;
    em_elem   = '0;
    em_idx    = '0;
    em_last   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready = 1'b1;
          cmd_nxt   = pop_cmd;
          unique case (pop_cmd.kind)
            CMD_REPORT: begin
              em        = 1'b1;
              em_status = pop_cmd.status;
            end
            CMD_CLEAR: begin
              head_nxt = LINK_NIL;
              em       = 1'b1;
            end
            CMD_INS_HEAD: begin
              mem_req.link_we    = 1'b1;
              mem_req.val_we     = 1'b1;
              mem_req.waddr      = pop_cmd.node;
              mem_req.link_wdata = head_r;
              mem_req.val_wdata  = pop_cmd.value;
              head_nxt           = {1'b0, pop_cmd.node};
              em                 = 1'b1;
              em_idx             = pop_cmd.node;
            end
            CMD_INS_AFTER: begin
              mem_req.raddr = pop_cmd.pos;
              state_nxt     = ST_INS_RD;
            end
            CMD_DELETE: begin
              if (pop_cmd.count == '0) begin
                em = 1'b1;
              end else begin
                mem_req.raddr = pop_cmd.pos;
                rem_nxt       = pop_cmd.count;
                state_nxt     = ST_DEL_LD;
              end
            end
            CMD_TRAVERSE: begin
              if (head_r >= LINK_NIL) begin
                em = 1'b1;
              end else begin
                mem_req.raddr = head_r[NODE_W-1:0];
                cur_nxt       = head_r[NODE_W-1:0];
                k_nxt         = '0;
                state_nxt     = ST_TRV_RD;
              end
            end
            default: begin
              em = 1'b1;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        // new node takes over the successor of the given node
        mem_req.link_we    = 1'b1;
        mem_req.val_we     = 1'b1;
        mem_req.waddr      = cmd_r.node;
        mem_req.link_wdata = link_rdata;
        mem_req.val_wdata  = cmd_r.value;
        state_nxt          = ST_INS_WR;
      end
      ST_INS_WR: begin
        if (out_free) begin
          mem_req.link_we    = 1'b1;
          mem_req.waddr      = cmd_r.pos;
          mem_req.link_wdata = {1'b0, cmd_r.node};
          em                 = 1'b1;
          em_idx             = cmd_r.node;
          state_nxt          = ST_IDLE;
        end
      end
      ST_DEL_LD: begin
        nx_nxt    = link_rdata;
        state_nxt = ST_DEL_CHK;
      end
      ST_DEL_CHK: begin
        if (rem_r == '0 || nx_r >= LINK_NIL) begin
          if (out_free) begin
            em        = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          mem_req.raddr = nx_r[NODE_W-1:0];
          state_nxt     = ST_DEL_RD;
        end
      end
      ST_DEL_RD: begin
        // skip one node: pos now points where the unlinked node pointed
        mem_req.link_we    = 1'b1;
        mem_req.waddr      = cmd_r.pos;
        mem_req.link_wdata = link_rdata;
        nx_nxt             = link_rdata;
        rem_nxt            = rem_r - COUNT_W'(1);
        state_nxt          = ST_DEL_CHK;
      end
      ST_TRV_RD: begin
        nx_nxt    = link_rdata;
        val_nxt   = val_rdata;
        state_nxt = ST_TRV_EM;
      end
      ST_TRV_EM: begin
        if (out_free) begin
          em      = 1'b1;
          em_has  = 1'b1;
          em_elem = val_r;
          em_idx  = cur_r;
          em_last = trv_fin;
          if (trv_fin) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_req.raddr = nx_r[NODE_W-1:0];
            cur_nxt       = nx_r[NODE_W-1:0];
            k_nxt         = k_r + NODE_W'(1);
            state_nxt     = ST_TRV_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_has_nxt    = out_has_r;
    out_elem_nxt   = out_elem_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    if (em) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = em_status;
      out_has_nxt    = em_has;
      out_elem_nxt   = em_elem;
      out_idx_nxt    = em_idx;
      out_last_nxt   = em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= LINK_NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    nx_r         <= nx_nxt;
    rem_r        <= rem_nxt;
    cur_r        <= cur_nxt;
    k_r          <= k_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_has_r    <= out_has_nxt;
    out_elem_r   <= out_elem_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== src/array_pool_linked_list.sv =====
// Clear, insert at head, delete of zero nodes and rejected ops give their result from the
// idle state; insert after reads the given node's link, writes the new node, then relinks;
// delete unlinks one node per read-and-write pass; traverse reads and emits element by element.
// Throughput: one op at a time in the list engine; a 2-entry queue lets the input run ahead.
// Reset: head pointer, allocation count, queue and output valid clear; node memories
// are not cleared, only allocated nodes are ever read.
module array_pool_linked_list import apl_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  apl_in_if.sink    in_chan,
  apl_out_if.source out_chan
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  logic                      push_valid, push_ready;
  cmd_t                      push_cmd;
  logic                      pop_valid, pop_ready;
  cmd_t                      pop_cmd;
  mem_req_t                  mem_req;
  logic [LINK_W-1:0]         link_rdata;
  logic [VALUE_W-1:0]        val_rdata;

  apl_front #(.POOL_DEPTH(POOL_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  apl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  apl_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready),
    .out_chan   (out_chan),
    .mem_req    (mem_req),
    .link_rdata (link_rdata),
    .val_rdata  (signed'(val_rdata))
  );

  apl_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (mem_req.link_we),
    .waddr (mem_req.waddr[AW-1:0]),
    .wdata (mem_req.link_wdata),
    .raddr (mem_req.raddr[AW-1:0]),
    .rdata (link_rdata)
  );

  apl_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (mem_req.val_we),
    .waddr (mem_req.waddr[AW-1:0]),
    .wdata (unsigned'(mem_req.val_wdata)),
    .raddr (mem_req.raddr[AW-1:0]),
    .rdata (val_rdata)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> pop_valid)
    else $error("command taken from empty queue");

  a_alloc_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_ready &&
     (push_cmd.kind == CMD_INS_HEAD || push_cmd.kind == CMD_INS_AFTER))
    |-> ({1'b0, push_cmd.node} < LINK_W'(POOL_DEPTH)))
    else $error("node allocated beyond pool");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != STATUS_OK)
    |-> (out_chan.last && !out_chan.has_value && out_chan.element == '0))
    else $error("error result not a lone final transaction");

  a_element_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.has_value) |-> (out_chan.status == STATUS_OK))
    else $error("traversed element with error status");

endmodule

// ===== bench/array_pool_linked_list_test.sv =====
module array_pool_linked_list_test;
  import apl_pkg::*;

  localparam int POOL_DEPTH  = 64;
  localparam int RANDOM_OPS  = 220;
  localparam int CHECK_CAP   = 40;

  // op codes the block answers with a plain ok and ignores
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [NODE_W-1:0]         position;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      has_value;
    logic signed [VALUE_W-1:0] element;
    logic [NODE_W-1:0]         node_index;
    logic                      last;
  } list_result_t;

  typedef struct packed {
    list_cmd_t    cmd;
    logic [6:0]   reps;
    logic         typed;
    list_result_t res;
  } script_row_t;

  localparam list_result_t RES_NONE    = '0;
  localparam list_result_t RES_OK      = '{STATUS_OK, 1'b0, 32'sd0, 6'd0, 1'b1};
  localparam list_result_t RES_FULL    = '{STATUS_FULL, 1'b0, 32'sd0, 6'd0, 1'b1};
  localparam list_result_t RES_BAD_POS = '{STATUS_BAD_POS, 1'b0, 32'sd0, 6'd0, 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  apl_in_if  in_chan ();
  apl_out_if out_chan ();

  array_pool_linked_list #(.POOL_DEPTH(POOL_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the node pool
  logic signed [VALUE_W-1:0] pool_vals  [POOL_DEPTH];
  logic [LINK_W-1:0]         pool_links [POOL_DEPTH];
  logic [LINK_W-1:0]         head_ptr = LINK_NIL;
  int                        pool_used = 0;

  list_result_t due_results [$];

  int  mismatch_count = 0;
  int  cmd_count      = 0;
  int  result_count   = 0;
  int  element_count  = 0;
  int  full_count     = 0;
  int  bad_pos_count  = 0;
  bit  no_idle        = 1'b0;

  script_row_t script_rows [26] = '{
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b1, RES_OK},
    '{'{OP_DELETE,    6'd0,  32'sd0,           7'd1},   7'd1,  1'b1, RES_BAD_POS},
    '{'{OP_INS_AFTER, 6'd0,  32'sd5,           7'd0},   7'd1,  1'b1, RES_BAD_POS},
    '{'{OP_INS_HEAD,  6'd0,  32'sh7fffffff,    7'd0},   7'd1,  1'b1,
      '{STATUS_OK, 1'b0, 32'sd0, 6'd0, 1'b1}},
    '{'{OP_INS_HEAD,  6'd63, 32'sh80000000,    7'd127}, 7'd1,  1'b1,
      '{STATUS_OK, 1'b0, 32'sd0, 6'd1, 1'b1}},
    '{'{OP_INS_AFTER, 6'd0,  32'shffffffff,    7'd0},   7'd1,  1'b1,
      '{STATUS_OK, 1'b0, 32'sd0, 6'd2, 1'b1}},
    '{'{OP_INS_AFTER, 6'd1,  32'sd0,           7'd0},   7'd1,  1'b1,
      '{STATUS_OK, 1'b0, 32'sd0, 6'd3, 1'b1}},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b0, RES_NONE},
    '{'{OP_DELETE,    6'd1,  32'sd0,           7'd0},   7'd1,  1'b1, RES_OK},
    '{'{OP_DELETE,    6'd1,  32'sd0,           7'd1},   7'd1,  1'b1, RES_OK},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b0, RES_NONE},
    '{'{OP_DELETE,    6'd0,  32'sd0,           7'd127}, 7'd1,  1'b1, RES_OK},
    '{'{OP_DELETE,    6'd63, 32'sd0,           7'd64},  7'd1,  1'b1, RES_BAD_POS},
    '{'{OP_RSVD5,     6'd63, 32'shffffffff,    7'd127}, 7'd1,  1'b1, RES_OK},
    '{'{OP_RSVD6,     6'd21, 32'sh55555555,    7'd42},  7'd1,  1'b1, RES_OK},
    '{'{OP_RSVD7,     6'd42, 32'shaaaaaaaa,    7'd85},  7'd1,  1'b1, RES_OK},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b0, RES_NONE},
    '{'{OP_CLEAR,     6'd0,  32'sd0,           7'd0},   7'd1,  1'b1, RES_OK},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b1, RES_OK},
    // fill the pool to the brim, values step by one per insert
    '{'{OP_INS_HEAD,  6'd0,  32'sh5a5a0000,    7'd0},   7'd64, 1'b0, RES_NONE},
    '{'{OP_INS_HEAD,  6'd0,  32'sd1,           7'd0},   7'd1,  1'b1, RES_FULL},
    '{'{OP_INS_AFTER, 6'd63, 32'sd2,           7'd0},   7'd1,  1'b1, RES_FULL},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b0, RES_NONE},
    '{'{OP_DELETE,    6'd63, 32'sd0,           7'd127}, 7'd1,  1'b1, RES_OK},
    '{'{OP_TRAVERSE,  6'd0,  32'sd0,           7'd0},   7'd1,  1'b0, RES_NONE},
    '{'{OP_CLEAR,     6'd0,  32'sd0,           7'd0},   7'd1,  1'b1, RES_OK}
  };

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= CHECK_CAP)
      $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic void queue_result(input logic [STATUS_W-1:0] st, input logic has,
                                       input logic signed [VALUE_W-1:0] elem,
                                       input logic [NODE_W-1:0] node, input logic fin);
    list_result_t r;
    r.status     = st;
    r.has_value  = has;
    r.element    = elem;
    r.node_index = node;
    r.last       = fin;
    due_results.push_back(r);
  endfunction

  // advances the shadow pool by one command and queues what the block must return
  function automatic void predict_list_op(input list_cmd_t c);
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nx;
    logic [NODE_W-1:0] n;
    int                k;
    case (c.op)
      OP_CLEAR: begin
        pool_used = 0;
        head_ptr  = LINK_NIL;
        queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
      end
      OP_INS_HEAD: begin
        if (pool_used >= POOL_DEPTH) begin
          queue_result(STATUS_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          n             = NODE_W'(pool_used);
          pool_vals[n]  = c.value;
          pool_links[n] = head_ptr;
          head_ptr      = LINK_W'(n);
          pool_used++;
          queue_result(STATUS_OK, 1'b0, '0, n, 1'b1);
        end
      end
      OP_INS_AFTER: begin
        if (int'(c.position) >= pool_used) begin
          queue_result(STATUS_BAD_POS, 1'b0, '0, '0, 1'b1);
        end else if (pool_used >= POOL_DEPTH) begin
          queue_result(STATUS_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          n                      = NODE_W'(pool_used);
          pool_vals[n]           = c.value;
          pool_links[n]          = pool_links[c.position];
          pool_links[c.position] = LINK_W'(n);
          pool_used++;
          queue_result(STATUS_OK, 1'b0, '0, n, 1'b1);
        end
      end
      OP_DELETE: begin
        if (int'(c.position) >= pool_used) begin
          queue_result(STATUS_BAD_POS, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(c.count); i++) begin
            nx = pool_links[c.position];
            if (nx >= LINK_NIL) break;
            pool_links[c.position] = pool_links[nx[NODE_W-1:0]];
          end
          queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_TRAVERSE: begin
        cur = head_ptr;
        k   = 0;
        if (cur >= LINK_NIL) begin
          queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
        end else begin
          while (cur < LINK_NIL && k < POOL_DEPTH) begin
            nx = pool_links[cur[NODE_W-1:0]];
            queue_result(STATUS_OK, 1'b1, pool_vals[cur[NODE_W-1:0]], cur[NODE_W-1:0],
                         (nx >= LINK_NIL) || (k + 1 >= POOL_DEPTH));
            k++;
            cur = nx;
          end
        end
      end
      default: begin
        queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // present one command, hold it until taken, then book its expected results
  task automatic send_cmd(input list_cmd_t c, input bit typed, input list_result_t typed_res);
    int mark;
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.op       <= c.op;
    in_chan.position <= c.position;
    in_chan.value    <= c.value;
    in_chan.count    <= c.count;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    mark = due_results.size();
    predict_list_op(c);
    if (typed) begin
      while (due_results.size() > mark) void'(due_results.pop_back());
      due_results.push_back(typed_res);
    end
    cmd_count++;
  endtask

  // result side: random back-pressure and in-order checking
  always @(posedge clk) begin
    list_result_t want;
    out_chan.ready <= no_idle || ($urandom_range(0, 99) >= 33);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction: status %0d element %0d node %0d",
                                out_chan.status, out_chan.element, out_chan.node_index));
      end else begin
        want = due_results.pop_front();
        result_count++;
        if (want.has_value) element_count++;
        if (want.status == STATUS_FULL) full_count++;
        if (want.status == STATUS_BAD_POS) bad_pos_count++;
        if (out_chan.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_chan.status, want.status));
        if (out_chan.has_value !== want.has_value)
          flag_mismatch($sformatf("has_value %0b, want %0b", out_chan.has_value,
                                  want.has_value));
        if (out_chan.element !== want.element)
          flag_mismatch($sformatf("element %0d, want %0d", out_chan.element, want.element));
        if (out_chan.node_index !== want.node_index)
          flag_mismatch($sformatf("node_index %0d, want %0d", out_chan.node_index,
                                  want.node_index));
        if (out_chan.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_chan.last, want.last));
      end
    end
  end

  initial begin
    list_cmd_t cmd;
    int        pick;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.op       <= OP_CLEAR;
    in_chan.position <= '0;
    in_chan.value    <= '0;
    in_chan.count    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_rows[i]) begin
      for (int rep = 0; rep < int'(script_rows[i].reps); rep++) begin
        cmd       = script_rows[i].cmd;
        cmd.value = cmd.value + rep;
        send_cmd(cmd, script_rows[i].typed, script_rows[i].res);
      end
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      no_idle      = (n >= 150 && n < 200);
      pick         = $urandom_range(0, 99);
      cmd.position = 6'($urandom_range(0, 63));
      cmd.value    = $urandom;
      cmd.count    = (pick % 10 < 7) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
      if (pick < 1 || (pool_used >= POOL_DEPTH && pick < 25)) begin
        cmd.op = OP_CLEAR;
      end else if (pick < 30) begin
        cmd.op = OP_INS_HEAD;
      end else if (pick < 75) begin
        cmd.op = (pick < 55) ? OP_INS_AFTER : OP_DELETE;
        // mostly a live node; now and then any index at all
        if (pool_used > 0 && $urandom_range(0, 9) != 0)
          cmd.position = 6'($urandom_range(0, pool_used - 1));
      end else if (pick < 93) begin
        cmd.op = OP_TRAVERSE;
      end else if (pick < 96) begin
        cmd.op = 3'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7)));
      end else begin
        cmd.op = pick[0] ? OP_INS_AFTER : OP_DELETE;
        if (pool_used < POOL_DEPTH)
          cmd.position = 6'($urandom_range(pool_used, POOL_DEPTH - 1));
      end
      send_cmd(cmd, 1'b0, RES_NONE);
    end
    no_idle = 1'b0;

    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("run covered %0d commands and %0d result transactions (%0d list elements)",
             cmd_count, result_count, element_count);
    $display("rejections seen: %0d pool full, %0d bad position; %0d mismatches",
             full_count, bad_pos_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/apl_pkg.sv
src/apl_if.sv
src/apl_ram.sv
src/apl_front.sv
src/apl_queue.sv
src/apl_back.sv
src/array_pool_linked_list.sv
bench/array_pool_linked_list_test.sv
